/* rtl/core/sem_pkg.sv */
// Shared types, widths and register codes of the Sobel edge magnitude block.
package sem_pkg;

   // Field and register widths
   localparam int PIXEL_W           = 8;
   localparam int CFG_WIDTH_W       = 9;
   localparam int CFG_HEIGHT_W      = 13;
   localparam int ROW_W             = 12;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 3;

   // Frame geometry limits and reset values
   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int MIN_DIM            = 3;
   localparam int MAX_HEIGHT         = 4096;
   localparam int FRAME_WIDTH_RESET  = 256;
   localparam int FRAME_HEIGHT_RESET = 256;

   // A window is complete once two earlier lines and columns are present
   localparam int WINDOW_LAG        = 2;
   localparam int WIN_TAPS          = 9;

   // Gradient arithmetic: weighted column sum and magnitude widths
   localparam int SUM_W             = 10;
   localparam int MAG_W             = 11;
   localparam int EDGE_MAX          = 255;

   // Queue between front and back
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Register indexes, taken from address bit 2
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CFG_WIDTH_W-1:0]  frame_width;
      logic [CFG_HEIGHT_W-1:0] frame_height;
   } cfg_type;

   // Window taps are indexed row*3+col, row 0 on top, col 0 on the left
   typedef struct packed {
      logic                             last_of_frame;
      logic [WIN_TAPS-1:0][PIXEL_W-1:0] pixels;
   } window_type;

endpackage

/* rtl/core/sem_front.sv */
// Front end: pixel acceptance, position counters, line stores and the 3x3 window.
module sem_front #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sem_pkg::cfg_type                 cfg,
   input  logic [sem_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                             req_frame_start,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [sem_pkg::QUEUE_CNT_W-1:0]  queue_count,
   output logic                             queue_push,
   output sem_pkg::window_type              queue_data
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int MAXW_W  = $clog2(MAX_WIDTH + 1);
   localparam int WCMP_W  = (sem_pkg::CFG_WIDTH_W > MAXW_W) ? sem_pkg::CFG_WIDTH_W : MAXW_W;
   localparam int HCMP_W  = sem_pkg::CFG_HEIGHT_W;
   localparam int ROW_W   = sem_pkg::ROW_W;
   localparam int PIX_W   = sem_pkg::PIXEL_W;
   localparam int CNT_W   = sem_pkg::QUEUE_CNT_W;

   // Line stores
   logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
   logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

   logic [COL_W-1:0]  col_ff, col_in, col_cur;
   logic [ROW_W-1:0]  row_ff, row_in, row_cur;
   logic [WCMP_W-1:0] width_ext, width_eff;
   logic [HCMP_W-1:0] height_eff;
   logic              accept;
   logic              col_wrap, row_wrap;
   logic              emit_cur, last_cur;

   // Stage one: read data and the accepted item's payload
   logic                  s1_valid_ff;
   logic [PIX_W-1:0]      s1_pixel_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic                  s1_emit_ff;
   logic                  s1_last_ff;
   logic                  s1_fwd_ff;
   logic [PIX_W-1:0]      fwd_data_ff;
   logic [PIX_W-1:0]      up_rd_ff, mid_rd_ff, up_eff;

   logic [sem_pkg::WIN_TAPS-1:0][PIX_W-1:0] window_ff, window_in;

   // Clamp the configured frame size to the supported range
   always_comb begin
      width_ext = WCMP_W'(cfg.frame_width);
      if (width_ext < WCMP_W'(sem_pkg::MIN_DIM)) begin
         width_eff = WCMP_W'(sem_pkg::MIN_DIM);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         width_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      if (cfg.frame_height < HCMP_W'(sem_pkg::MIN_DIM)) begin
         height_eff = HCMP_W'(sem_pkg::MIN_DIM);
      end else if (cfg.frame_height > HCMP_W'(sem_pkg::MAX_HEIGHT)) begin
         height_eff = HCMP_W'(sem_pkg::MAX_HEIGHT);
      end else begin
         height_eff = cfg.frame_height;
      end
   end

   // Hold off when the queue cannot take what is already in flight
   assign req_full = ({1'b0, queue_count} + (CNT_W + 1)'(s1_valid_ff))
                     >= (CNT_W + 1)'(sem_pkg::QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   // Position of the incoming pixel and the next position
   always_comb begin
      col_cur  = req_frame_start ? '0 : col_ff;
      row_cur  = req_frame_start ? '0 : row_ff;
      emit_cur = (row_cur >= ROW_W'(sem_pkg::WINDOW_LAG))
                 && (col_cur >= COL_W'(sem_pkg::WINDOW_LAG));
      last_cur = (row_cur == ROW_W'(height_eff - HCMP_W'(1)))
                 && (WCMP_W'(col_cur) == width_eff - WCMP_W'(1));
      col_wrap = (WCMP_W'(col_cur) + WCMP_W'(1)) >= width_eff;
      row_wrap = (HCMP_W'(row_cur) + HCMP_W'(1)) >= height_eff;
      col_in   = col_wrap ? '0 : col_cur + COL_W'(1);
      if (col_wrap) begin
         row_in = row_wrap ? '0 : row_cur + ROW_W'(1);
      end else begin
         row_in = row_cur;
      end
   end

   // Advance the counters and the stage-one valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // Read both line stores, push the new pixel into the middle one
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff               <= mem_upper[col_cur];
         mid_rd_ff              <= mem_middle[col_cur];
         mem_middle[col_cur]    <= req_pixel;
         s1_pixel_ff            <= req_pixel;
         s1_col_ff              <= col_cur;
         s1_emit_ff             <= emit_cur;
         s1_last_ff             <= last_cur;
         // Same column as the item now retiring its upper-store write
         s1_fwd_ff              <= s1_valid_ff && (s1_col_ff == col_cur);
         fwd_data_ff            <= mid_rd_ff;
      end
      // Move the old middle line entry up one line
      if (s1_valid_ff) begin
         mem_upper[s1_col_ff] <= mid_rd_ff;
      end
   end

   assign up_eff = s1_fwd_ff ? fwd_data_ff : up_rd_ff;

   // Shift the window left and fill its right column
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[r * 3]     = window_ff[r * 3 + 1];
         window_in[r * 3 + 1] = window_ff[r * 3 + 2];
      end
      window_in[2] = up_eff;
      window_in[5] = mid_rd_ff;
      window_in[8] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   // Hand complete windows to the back end
   assign queue_push               = s1_valid_ff && s1_emit_ff;
   assign queue_data.pixels        = window_in;
   assign queue_data.last_of_frame = s1_last_ff;

   // A window pushed into the queue always finds room
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> (queue_count < CNT_W'(sem_pkg::QUEUE_DEPTH)))
      else $error("front pushed a window into a full queue");

endmodule

/* rtl/core/sem_queue.sv */
// Short window queue between the front and back ends.
module sem_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  sem_pkg::window_type              push_data,
   input  logic                             pop,
   output sem_pkg::window_type              pop_data,
   output logic                             empty,
   output logic [sem_pkg::QUEUE_CNT_W-1:0]  count
);

   localparam int PTR_W = sem_pkg::QUEUE_PTR_W;
   localparam int CNT_W = sem_pkg::QUEUE_CNT_W;

   sem_pkg::window_type entries_ff [sem_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed window
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entries_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(sem_pkg::QUEUE_DEPTH)))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue underflow");

endmodule

/* rtl/core/sem_back.sv */
// Back end: gradient magnitudes, saturating sum and the result register.
module sem_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           queue_empty,
   input  sem_pkg::window_type            queue_data,
   output logic                           queue_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [sem_pkg::PIXEL_W-1:0]    rsp_edge_value,
   output logic                           rsp_last_of_frame
);

   localparam int SUM_W = sem_pkg::SUM_W;
   localparam int MAG_W = sem_pkg::MAG_W;
   localparam int PIX_W = sem_pkg::PIXEL_W;

   logic [SUM_W-1:0] right_sum, left_sum, top_sum, bot_sum;
   logic [SUM_W-1:0] gx_abs, gy_abs;
   logic [MAG_W-1:0] mag;

   logic             b1_valid_ff;
   logic [SUM_W-1:0] gx_ff, gy_ff;
   logic             b1_last_ff;

   logic             out_valid_ff;
   logic [PIX_W-1:0] edge_ff;
   logic             out_last_ff;

   logic             out_load, b1_advance;

   // Weighted column and row sums, then absolute differences
   always_comb begin
      right_sum = SUM_W'(queue_data.pixels[2]) + (SUM_W'(queue_data.pixels[5]) << 1)
                + SUM_W'(queue_data.pixels[8]);
      left_sum  = SUM_W'(queue_data.pixels[0]) + (SUM_W'(queue_data.pixels[3]) << 1)
                + SUM_W'(queue_data.pixels[6]);
      top_sum   = SUM_W'(queue_data.pixels[0]) + (SUM_W'(queue_data.pixels[1]) << 1)
                + SUM_W'(queue_data.pixels[2]);
      bot_sum   = SUM_W'(queue_data.pixels[6]) + (SUM_W'(queue_data.pixels[7]) << 1)
                + SUM_W'(queue_data.pixels[8]);
      gx_abs    = (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
      gy_abs    = (top_sum >= bot_sum) ? top_sum - bot_sum : bot_sum - top_sum;
   end

   // Pipeline flow: the result register drains on pop, stage one feeds it
   assign out_load   = b1_valid_ff && (!out_valid_ff || rsp_pop);
   assign b1_advance = !b1_valid_ff || out_load;
   assign queue_pop  = !queue_empty && b1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (b1_advance) begin
            b1_valid_ff <= queue_pop;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         gx_ff      <= gx_abs;
         gy_ff      <= gy_abs;
         b1_last_ff <= queue_data.last_of_frame;
      end
   end

   // Add the magnitudes and saturate
   assign mag = MAG_W'(gx_ff) + MAG_W'(gy_ff);

   always_ff @(posedge clock) begin
      if (out_load) begin
         edge_ff     <= (mag > MAG_W'(sem_pkg::EDGE_MAX)) ? PIX_W'(sem_pkg::EDGE_MAX)
                                                          : mag[PIX_W-1:0];
         out_last_ff <= b1_last_ff;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_edge_value    = edge_ff;
   assign rsp_last_of_frame = out_last_ff;

   // A gradient pair that cannot move on is held, not dropped
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (b1_valid_ff && !out_load) |=> (b1_valid_ff && $stable(gx_ff) && $stable(gy_ff)))
      else $error("gradient stage lost a transaction");

endmodule

/* rtl/core/sobel_edge_magnitude.sv */
// Sobel 3x3 edge magnitude: top level with the configuration registers.
// A result passes the read stage, window queue, gradient stage and result register.
// Throughput: one pixel per cycle while req_full is low; req_full rises only when the
// window queue and the pixel in the line store read stage would fill its 4 entries.
// Reset: counters, window and the queue clear; frame size returns to 256 x 256.
// The line stores are not cleared; they fill as pixels arrive.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Pixel input
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [sem_pkg::PIXEL_W-1:0]       req_pixel,
   input  logic                              req_frame_start,
   // Edge results
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [sem_pkg::PIXEL_W-1:0]       rsp_edge_value,
   output logic                              rsp_last_of_frame,
   // Configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sem_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sem_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sem_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int DATA_W = sem_pkg::CSR_DATA_W;

   logic [sem_pkg::CFG_WIDTH_W-1:0]  frame_width_ff;
   logic [sem_pkg::CFG_HEIGHT_W-1:0] frame_height_ff;
   logic                             csr_write;
   sem_pkg::reg_index_type           reg_index;
   sem_pkg::cfg_type                 cfg;

   logic                             queue_push, queue_pop, queue_empty;
   sem_pkg::window_type              queue_wr_data, queue_rd_data;
   logic [sem_pkg::QUEUE_CNT_W-1:0]  queue_count;

   // Decode register transactions
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = sem_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= sem_pkg::CFG_WIDTH_W'(sem_pkg::FRAME_WIDTH_RESET);
         frame_height_ff <= sem_pkg::CFG_HEIGHT_W'(sem_pkg::FRAME_HEIGHT_RESET);
      end else if (csr_write) begin
         unique case (reg_index)
            sem_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_pwdata[sem_pkg::CFG_WIDTH_W-1:0];
            end
            sem_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_pwdata[sem_pkg::CFG_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (reg_index)
         sem_pkg::REG_FRAME_WIDTH:  csr_prdata = DATA_W'(frame_width_ff);
         sem_pkg::REG_FRAME_HEIGHT: csr_prdata = DATA_W'(frame_height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;

   sem_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .req_push        (req_push),
      .req_full        (req_full),
      .queue_count     (queue_count),
      .queue_push      (queue_push),
      .queue_data      (queue_wr_data)
   );

   sem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_wr_data),
      .pop       (queue_pop),
      .pop_data  (queue_rd_data),
      .empty     (queue_empty),
      .count     (queue_count)
   );

   sem_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .queue_data        (queue_rd_data),
      .queue_pop         (queue_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_edge_value    (rsp_edge_value),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
